@@ src/tccs_pkg.sv @@
package tccs_pkg;

  // Field widths of one item
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned NODE_W  = 5;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned CYC_W   = 6;
  localparam int unsigned SCORE_W = 7;

  // Score scale factor
  localparam int unsigned SCORE_SCALE = 99;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SET   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RUN   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP   = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [NODE_W-1:0]  from_node;
    logic [NODE_W-1:0]  to_node;
    logic [COUNT_W-1:0] node_count;
  } tccs_in_t;

  typedef struct packed {
    logic [CYC_W-1:0]   cyclic_nodes;
    logic [SCORE_W-1:0] score;
  } tccs_out_t;

  // Row memory command
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } tccs_mem_cmd_t;

endpackage

@@ src/tccs_mem.sv @@
module tccs_mem
  import tccs_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tccs_mem_cmd_t            cmd,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] q_r;
  logic             qv_r;

  // Row storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      q_r <= mem[rd_addr];
    end
  end

  // Per-row valid bits; an invalid row reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (cmd.clr) begin
        vld_r <= '0;
      end else if (cmd.wr) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd) begin
        qv_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = qv_r ? q_r : '0;

endmodule

@@ src/tccs_div.sv @@
module tccs_div
  import tccs_pkg::*;
#(
  parameter int unsigned NUM_W = 13,
  parameter int unsigned DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    step_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             fits;

  // One quotient bit per cycle, restoring
  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    fits    = rem_sh >= {1'b0, den_r};
    rem_dif = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
        step_r <= CW'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= fits ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo_r  <= {quo_r[NUM_W-2:0], fits};
        step_r <= step_r - CW'(1);
        if (step_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ src/transitive_closure_cycle_score.sv @@
// Clear: accepted in idle, with no further steps. Set edge: row read, then write back.
// Run over n nodes: each pivot row is read and loaded, then the closure reads one
// row per cycle; then the diagonal is counted, and the 13-step divider and the
// result register give the score.
// One item at a time; the result register frees the input while a result waits.
// Reset (synchronous, rst_n low) clears every row valid bit and empties the output.
module transitive_closure_cycle_score
  import tccs_pkg::*;
#(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tccs_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tccs_out_t out_data
);

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned NW = $clog2(MAX_NODES + 1);
  localparam int unsigned PW = NW + SCORE_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_WR,
    S_PIV_RD,
    S_PIV_LD,
    S_ROW,
    S_ROW_END,
    S_CNT,
    S_CNT_END,
    S_DIV_GO,
    S_DIV,
    S_OUT
  } state_t;

  state_t               state_r;
  logic [NW-1:0]        n_r;
  logic [NW-1:0]        i_r;
  logic [IW-1:0]        j_r;
  logic                 pend_r;
  logic [IW-1:0]        pend_idx_r;
  logic [MAX_NODES-1:0] pivot_r;
  logic [NW-1:0]        cnt_r;
  logic [IW-1:0]        from_r;
  logic [IW-1:0]        to_r;
  logic [SCORE_W-1:0]   score_r;
  logic                 out_valid_r;
  tccs_out_t            out_data_r;

  tccs_mem_cmd_t        mem_cmd;
  logic [IW-1:0]        mem_rd_addr;
  logic [IW-1:0]        mem_wr_addr;
  logic [MAX_NODES-1:0] mem_wr_data;
  logic [MAX_NODES-1:0] row_q;

  logic [MAX_NODES-1:0] row_mask;
  logic [NW-1:0]        n_clamp;
  logic                 edge_ok;
  logic [IW-1:0]        i_idx;
  logic                 row_hit;
  logic                 div_start;
  logic [PW-1:0]        div_num;
  logic                 div_done;
  logic [PW-1:0]        div_quo;
  logic                 out_free;

  assign i_idx    = i_r[IW-1:0];
  assign row_hit  = row_q[i_idx];
  assign out_free = !out_valid_r || !out_stall;

  // Node count clamp and edge range check
  always_comb begin
    if (int'(in_data.node_count) > MAX_NODES) begin
      n_clamp = NW'(MAX_NODES);
    end else begin
      n_clamp = NW'(in_data.node_count);
    end
    edge_ok = (int'(in_data.from_node) < MAX_NODES) && (int'(in_data.to_node) < MAX_NODES);
  end

  // Columns in use by the run
  always_comb begin
    for (int k = 0; k < MAX_NODES; k++) begin
      row_mask[k] = (k < int'(n_r));
    end
  end

  // Memory commands
  always_comb begin
    mem_cmd     = '0;
    mem_rd_addr = j_r;
    mem_wr_addr = pend_idx_r;
    mem_wr_data = row_q | pivot_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_data.action == ACT_CLEAR) begin
          mem_cmd.clr = 1'b1;
        end else if (in_valid && in_data.action == ACT_SET && edge_ok) begin
          mem_cmd.rd  = 1'b1;
          mem_rd_addr = IW'(in_data.from_node);
        end
      end
      S_SET_WR: begin
        mem_cmd.wr  = 1'b1;
        mem_wr_addr = from_r;
        mem_wr_data = row_q | (MAX_NODES'(1) << to_r);
      end
      S_PIV_RD: begin
        mem_cmd.rd  = (i_r != n_r);
        mem_rd_addr = i_idx;
      end
      S_ROW: begin
        mem_cmd.rd = 1'b1;
        mem_cmd.wr = pend_r && row_hit;
      end
      S_ROW_END: begin
        mem_cmd.wr = row_hit;
      end
      S_CNT: begin
        mem_cmd.rd = 1'b1;
      end
      S_PIV_LD, S_CNT_END, S_DIV_GO, S_DIV, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign div_start = (state_r == S_DIV_GO);
  assign div_num   = PW'(cnt_r) * PW'(SCORE_SCALE);

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            from_r <= IW'(in_data.from_node);
            to_r   <= IW'(in_data.to_node);
            n_r    <= n_clamp;
            i_r    <= '0;
            cnt_r  <= '0;
            if (in_data.action == ACT_SET && edge_ok) begin
              state_r <= S_SET_WR;
            end else if (in_data.action == ACT_RUN) begin
              state_r <= S_PIV_RD;
            end
          end
        end
        S_SET_WR: begin
          state_r <= S_IDLE;
        end
        S_PIV_RD: begin
          j_r    <= '0;
          pend_r <= 1'b0;
          if (i_r != n_r) begin
            state_r <= S_PIV_LD;
          end else if (n_r == '0) begin
            state_r <= S_DIV_GO;
          end else begin
            state_r <= S_CNT;
          end
        end
        S_PIV_LD: begin
          pivot_r <= row_q & row_mask;
          j_r     <= '0;
          pend_r  <= 1'b0;
          state_r <= S_ROW;
        end
        S_ROW: begin
          pend_r     <= 1'b1;
          pend_idx_r <= j_r;
          j_r        <= IW'(j_r + IW'(1));
          if (j_r == IW'(n_r - NW'(1))) begin
            state_r <= S_ROW_END;
          end
        end
        S_ROW_END: begin
          pend_r  <= 1'b0;
          i_r     <= i_r + NW'(1);
          state_r <= S_PIV_RD;
        end
        S_CNT: begin
          if (pend_r) begin
            cnt_r <= cnt_r + NW'(row_q[pend_idx_r]);
          end
          pend_r     <= 1'b1;
          pend_idx_r <= j_r;
          j_r        <= IW'(j_r + IW'(1));
          if (j_r == IW'(n_r - NW'(1))) begin
            state_r <= S_CNT_END;
          end
        end
        S_CNT_END: begin
          pend_r  <= 1'b0;
          state_r <= S_DIV_GO;
          cnt_r   <= cnt_r + NW'(row_q[pend_idx_r]);
        end
        S_DIV_GO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            score_r <= (n_r < NW'(2)) ? '0 : SCORE_W'(div_quo);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r.cyclic_nodes <= CYC_W'(cnt_r);
            out_data_r.score        <= score_r;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tccs_mem #(
    .DEPTH(MAX_NODES),
    .WIDTH(MAX_NODES)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (mem_cmd),
    .rd_addr(mem_rd_addr),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_data(row_q)
  );

  tccs_div #(
    .NUM_W(PW),
    .DEN_W(NW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_num),
    .divisor (n_r),
    .done    (div_done),
    .quotient(div_quo)
  );

endmodule

@@ src/tccs_chk.sv @@
module tccs_chk
  import tccs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input tccs_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input tccs_out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Score never exceeds the scale
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.score <= SCORE_W'(SCORE_SCALE))
    else $error("score out of range");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A run keeps the input stalled on the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.action == ACT_RUN |=> in_stall)
    else $error("run item did not block input");

  // A clear leaves the input unstalled on the next cycle
  a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.action == ACT_CLEAR |=> !in_stall)
    else $error("clear item held the input");

endmodule

bind transitive_closure_cycle_score tccs_chk u_chk (.*);
